>>> rtl/core/sla_pkg.sv
// Shared types and constants for the slot list allocator.
package sla_pkg;

  localparam int unsigned POOL_ENTRIES = 256;
  localparam int unsigned IDX_W        = $clog2(POOL_ENTRIES);
  localparam int unsigned LINK_W       = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned BK_W         = LINK_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  // "None" is stored as the pool size
  localparam link_t LINK_NONE  = LINK_W'(POOL_ENTRIES);
  localparam idx_t  SWEEP_LAST = IDX_W'(POOL_ENTRIES - 1);
  localparam link_t FREE_HEAD_RST = LINK_W'(1);
  localparam link_t TAIL_RST      = LINK_W'(0);
  localparam link_t COUNT_RST     = LINK_W'(1);

  typedef enum logic [1:0] {
    FUNC_INIT   = 2'd0,
    FUNC_ALLOC  = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_HEAD     = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEQ_SWEEP,
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_WR2
  } seq_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] entry_index;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] entry_out;
    logic       entry_valid;
    logic [8:0] live_count;
  } result_t;

  // back-link memory word: in-use mark above the back link
  typedef struct packed {
    logic  mark;
    link_t back;
  } bk_t;

  localparam logic [BK_W-1:0] BK_MASK_ALL  = {BK_W{1'b1}};
  localparam logic [BK_W-1:0] BK_MASK_BACK = {1'b0, {LINK_W{1'b1}}};

  typedef struct packed {
    logic            we;
    idx_t            waddr;
    bk_t             wdata;
    logic [BK_W-1:0] wmask;
    idx_t            raddr;
  } bmem_req_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    link_t wdata;
    idx_t  raddr;
  } fmem_req_t;

endpackage

>>> rtl/core/sla_ram.sv
// Generic single-write, single-read synchronous RAM with bit write mask.
module sla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [WIDTH-1:0]         wmask_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int unsigned b = 0; b < WIDTH; b++) begin
        if (wmask_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i[b];
        end
      end
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sla_seq.sv
// Sequencer: read-modify-write of the link memories and list pointers.
module sla_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sla_pkg::item_t      in_i,
  input  logic                out_free_i,
  output logic                in_stall_o,
  input  sla_pkg::bk_t        bmem_rdata_i,
  input  sla_pkg::link_t      fmem_rdata_i,
  output sla_pkg::bmem_req_t  bmem_req_o,
  output sla_pkg::fmem_req_t  fmem_req_o,
  output logic                res_valid_o,
  output sla_pkg::result_t    res_o
);
  import sla_pkg::*;

  seq_state_e state_q, state_d;
  idx_t       sweep_q, sweep_d;
  logic       report_q, report_d;
  link_t      free_head_q, free_head_d;
  link_t      tail_q, tail_d;
  link_t      count_q, count_d;

  logic [1:0] func_q, func_d;
  idx_t       idx_q, idx_d;
  logic       idx_ok_q, idx_ok_d;
  logic       w2_en_q, w2_en_d;
  link_t      w2_addr_q, w2_addr_d;
  link_t      w2_data_q, w2_data_d;

  logic       fire;
  logic       is_tail;
  link_t      prev, next;

  assign prev    = bmem_rdata_i.back;
  assign next    = fmem_rdata_i;
  assign is_tail = (LINK_W'(idx_q) == tail_q);

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    report_d    = report_q;
    free_head_d = free_head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    func_d      = func_q;
    idx_d       = idx_q;
    idx_ok_d    = idx_ok_q;
    w2_en_d     = w2_en_q;
    w2_addr_d   = w2_addr_q;
    w2_data_d   = w2_data_q;

    bmem_req_o  = '0;
    fmem_req_o  = '0;
    // reads are only used from the accepting cycle
    if (in_i.func == FUNC_ALLOC) begin
      bmem_req_o.raddr = IDX_W'(free_head_q);
    end else begin
      bmem_req_o.raddr = IDX_W'(in_i.entry_index);
    end
    fmem_req_o.raddr = IDX_W'(in_i.entry_index);

    res_valid_o = 1'b0;
    res_o       = '0;

    in_stall_o  = !((state_q == SEQ_IDLE) && out_free_i);
    fire        = in_valid_i && !in_stall_o;

    case (state_q)
      SEQ_SWEEP: begin
        bmem_req_o.we         = 1'b1;
        bmem_req_o.waddr      = sweep_q;
        bmem_req_o.wmask      = BK_MASK_ALL;
        bmem_req_o.wdata.mark = (sweep_q == '0);
        bmem_req_o.wdata.back = (sweep_q == '0) ? LINK_NONE
                                                : LINK_W'(sweep_q) + LINK_W'(1);
        fmem_req_o.we         = 1'b1;
        fmem_req_o.waddr      = sweep_q;
        fmem_req_o.wdata      = LINK_NONE;
        if (sweep_q == SWEEP_LAST) begin
          state_d = SEQ_IDLE;
          if (report_q) begin
            res_valid_o       = 1'b1;
            res_o.status      = STAT_OK;
            res_o.entry_valid = 1'b1;
            res_o.live_count  = 9'(count_q);
          end
        end else begin
          sweep_d = sweep_q + IDX_W'(1);
        end
      end

      SEQ_IDLE: begin
        if (fire) begin
          func_d   = in_i.func;
          idx_d    = IDX_W'(in_i.entry_index);
          idx_ok_d = (32'(in_i.entry_index) < 32'(POOL_ENTRIES));
          if (in_i.func == FUNC_INIT) begin
            sweep_d     = '0;
            report_d    = 1'b1;
            free_head_d = FREE_HEAD_RST;
            tail_d      = TAIL_RST;
            count_d     = COUNT_RST;
            state_d     = SEQ_SWEEP;
          end else begin
            state_d = SEQ_EXEC;
          end
        end
      end

      SEQ_EXEC: begin
        state_d      = SEQ_IDLE;
        res_valid_o  = 1'b1;
        res_o.status = STAT_OK;
        case (func_q)
          FUNC_ALLOC: begin
            if (free_head_q == LINK_NONE) begin
              res_o.status = STAT_FULL;
            end else begin
              bmem_req_o.we         = 1'b1;
              bmem_req_o.waddr      = IDX_W'(free_head_q);
              bmem_req_o.wmask      = BK_MASK_ALL;
              bmem_req_o.wdata.mark = 1'b1;
              bmem_req_o.wdata.back = tail_q;
              fmem_req_o.we         = 1'b1;
              fmem_req_o.waddr      = IDX_W'(free_head_q);
              fmem_req_o.wdata      = LINK_NONE;
              free_head_d           = bmem_rdata_i.back;
              tail_d                = free_head_q;
              count_d               = count_q + LINK_W'(1);
              // old tail gets its forward link in the next cycle
              w2_en_d               = (tail_q < LINK_NONE);
              w2_addr_d             = tail_q;
              w2_data_d             = free_head_q;
              res_o.entry_out       = 8'(free_head_q);
              res_o.entry_valid     = 1'b1;
              state_d               = SEQ_WR2;
            end
          end

          FUNC_REMOVE: begin
            if (!idx_ok_q || !bmem_rdata_i.mark) begin
              res_o.status = STAT_NOT_USED;
            end else if (idx_q == '0) begin
              res_o.status = STAT_HEAD;
            end else begin
              bmem_req_o.we         = 1'b1;
              bmem_req_o.waddr      = idx_q;
              bmem_req_o.wmask      = BK_MASK_ALL;
              bmem_req_o.wdata.mark = 1'b0;
              bmem_req_o.wdata.back = free_head_q;
              fmem_req_o.we         = (prev < LINK_NONE);
              fmem_req_o.waddr      = IDX_W'(prev);
              fmem_req_o.wdata      = next;
              if (is_tail) begin
                tail_d = prev;
              end
              // successor's back link is patched in the next cycle
              w2_en_d     = !is_tail && (next < LINK_NONE);
              w2_addr_d   = next;
              w2_data_d   = prev;
              free_head_d = LINK_W'(idx_q);
              if (count_q != '0) begin
                count_d = count_q - LINK_W'(1);
              end
              state_d = SEQ_WR2;
            end
          end

          FUNC_READ: begin
            if (!idx_ok_q) begin
              res_o.status = STAT_NOT_USED;
            end else if (fmem_rdata_i < LINK_NONE) begin
              res_o.entry_out   = 8'(fmem_rdata_i);
              res_o.entry_valid = 1'b1;
            end
          end

          default: begin
          end
        endcase
        res_o.live_count = 9'(count_d);
      end

      SEQ_WR2: begin
        state_d = SEQ_IDLE;
        case (func_q)
          FUNC_ALLOC: begin
            fmem_req_o.we    = w2_en_q;
            fmem_req_o.waddr = IDX_W'(w2_addr_q);
            fmem_req_o.wdata = w2_data_q;
          end
          FUNC_REMOVE: begin
            bmem_req_o.we         = w2_en_q;
            bmem_req_o.waddr      = IDX_W'(w2_addr_q);
            bmem_req_o.wmask      = BK_MASK_BACK;
            bmem_req_o.wdata.back = w2_data_q;
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_SWEEP;
      sweep_q     <= '0;
      report_q    <= 1'b0;
      free_head_q <= FREE_HEAD_RST;
      tail_q      <= TAIL_RST;
      count_q     <= COUNT_RST;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      report_q    <= report_d;
      free_head_q <= free_head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    idx_q     <= idx_d;
    idx_ok_q  <= idx_ok_d;
    w2_en_q   <= w2_en_d;
    w2_addr_q <= w2_addr_d;
    w2_data_q <= w2_data_d;
  end

endmodule

>>> rtl/core/slot_list_allocator.sv
// Top level of the slot list allocator: link memories, sequencer, output register.
// A result passes from the sequencer's execute state into the output register; init gives
//   its result at the end of the rebuild pass.
// One at a time: read, full and refused operations execute only, allocate/remove add a
//   write-back state, init runs the rebuild pass; a stalled result also holds off input.
// Reset: list pointers reset at once, then a pass rewrites all POOL_ENTRIES rows of both
//   memories one row a cycle with in_stall_o held high; no result is produced for it.
module slot_list_allocator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sla_pkg::item_t   in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sla_pkg::result_t out_o
);
  import sla_pkg::*;

  // Memory requests from the sequencer
  bmem_req_t bmem_req;
  fmem_req_t fmem_req;
  bk_t       bmem_rdata;
  link_t     fmem_rdata;

  // Result hand-off into the output register
  logic      res_valid;
  result_t   res;
  logic      out_free;

  logic      out_valid_q;
  result_t   out_q;

  // Back links and in-use marks share one memory; the mark is masked out
  // when only a successor's back link is patched.
  sla_ram #(
    .WIDTH (BK_W),
    .DEPTH (POOL_ENTRIES)
  ) u_bmem (
    .clk_i   (clk_i),
    .we_i    (bmem_req.we),
    .waddr_i (bmem_req.waddr),
    .wdata_i (bmem_req.wdata),
    .wmask_i (bmem_req.wmask),
    .raddr_i (bmem_req.raddr),
    .rdata_o (bmem_rdata)
  );

  // Forward links
  sla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_ENTRIES)
  ) u_fmem (
    .clk_i   (clk_i),
    .we_i    (fmem_req.we),
    .waddr_i (fmem_req.waddr),
    .wdata_i (fmem_req.wdata),
    .wmask_i ({LINK_W{1'b1}}),
    .raddr_i (fmem_req.raddr),
    .rdata_o (fmem_rdata)
  );

  sla_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_i         (in_i),
    .out_free_i   (out_free),
    .in_stall_o   (in_stall_o),
    .bmem_rdata_i (bmem_rdata),
    .fmem_rdata_i (fmem_rdata),
    .bmem_req_o   (bmem_req),
    .fmem_req_o   (fmem_req),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // The output slot is free if empty or being taken this cycle. A new
  // transaction is only accepted then, so by the time its result is ready
  // the slot is guaranteed empty.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/core/sla_checker.sv
// Port-level checker for the slot list allocator, bound to the top level.
module sla_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input sla_pkg::item_t   in_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input sla_pkg::result_t out_o
);
  import sla_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // one transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a transaction while busy");

  // head always allocated, never more than the pool
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.live_count >= 9'd1) &&
                    (32'(out_o.live_count) <= 32'(POOL_ENTRIES)))
    else $error("live count out of range");

  // any error status names no entry
  a_err_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != STAT_OK) |->
      !out_o.entry_valid && (out_o.entry_out == 8'd0))
    else $error("error result carries an entry");

  // full pool reports the maximum count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == STAT_FULL) |->
      (32'(out_o.live_count) == 32'(POOL_ENTRIES)))
    else $error("pool full with free entries left");

endmodule

bind slot_list_allocator sla_checker u_sla_checker (.*);

>>> tb/slot_list_allocator_test.sv
// Self-checking testbench for the slot list allocator: directed table, then biased random traffic.
`timescale 1ns / 1ps

module slot_list_allocator_test;
  import sla_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 205;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned CYCLE_LIMIT      = 300000;

  // ---------------------------------------------------------------------------
  // Clock, reset and block hookup
  // ---------------------------------------------------------------------------
  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  item_t   in_item   = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  result_t out_result;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  slot_list_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_result)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the pool: free list threaded through the back links, in-use list
  // doubly linked in allocation order. LINK_NONE marks an absent link.
  // ---------------------------------------------------------------------------
  link_t       pool_back [POOL_ENTRIES];
  link_t       pool_fwd  [POOL_ENTRIES];
  bit          pool_used [POOL_ENTRIES];
  link_t       free_top;
  link_t       list_tail;
  int unsigned live_entries;

  result_t     pending_results [$];   // what the block owes us, oldest first

  // run bookkeeping
  int unsigned errors;
  int unsigned sent_count;
  int unsigned directed_count;
  int unsigned checked_count;
  int unsigned full_seen;
  int unsigned rejected_seen;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned cycle_count;

  // random traffic steering: climb towards a full pool, then drain to a low mark
  bit          climbing;
  int unsigned full_hits;
  int unsigned low_mark;
  idx_t        walk_pos;

  // Apply one transaction to the shadow pool and return the result it must give.
  function automatic result_t predict_result(item_t it);
    result_t r;
    link_t   n;
    link_t   prev;
    link_t   next;
    idx_t    g;
    int      i;
    r = '0;
    g = it.entry_index;
    case (it.func)
      FUNC_INIT: begin
        for (i = 0; i < POOL_ENTRIES; i++) begin
          pool_back[i] = link_t'(i + 1);
          pool_fwd[i]  = LINK_NONE;
          pool_used[i] = 1'b0;
        end
        pool_back[0]  = LINK_NONE;
        pool_used[0]  = 1'b1;
        free_top      = (POOL_ENTRIES > 1) ? link_t'(1) : LINK_NONE;
        list_tail     = '0;
        live_entries  = 1;
        r.entry_valid = 1'b1;   // the head, entry zero
      end
      FUNC_ALLOC: begin
        n = free_top;
        if (n >= LINK_NONE) begin
          r.status = STAT_FULL;
        end else begin
          free_top     = pool_back[n];
          pool_fwd[n]  = LINK_NONE;
          pool_back[n] = list_tail;
          if (list_tail < LINK_NONE) pool_fwd[list_tail] = n;
          list_tail    = n;
          pool_used[n] = 1'b1;
          live_entries++;
          r.entry_out   = n[7:0];
          r.entry_valid = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        // a free entry is refused before the head test; the head is always in use
        if (!pool_used[g]) begin
          r.status = STAT_NOT_USED;
        end else if (g == '0) begin
          r.status = STAT_HEAD;
        end else begin
          prev = pool_back[g];
          next = pool_fwd[g];
          if (link_t'(g) == list_tail) list_tail = prev;
          else if (next < LINK_NONE) pool_back[next] = prev;
          if (prev < LINK_NONE) pool_fwd[prev] = next;
          // forward link stays, so a walk can step on past a removed entry
          pool_back[g] = free_top;
          free_top     = link_t'(g);
          pool_used[g] = 1'b0;
          if (live_entries > 0) live_entries--;
        end
      end
      default: begin
        if (pool_fwd[g] < LINK_NONE) begin
          r.entry_out   = pool_fwd[g][7:0];
          r.entry_valid = 1'b1;
        end
      end
    endcase
    r.live_count = live_entries[8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: expected result typed in only where it is obvious.
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t   stim;
    int      reps;
    bit      known;
    result_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  function automatic void add_row(func_e op, int unsigned idx, int reps, bit known = 1'b0,
                                  status_e st = STAT_OK, int unsigned eo = 0, bit ev = 1'b0,
                                  int unsigned cnt = 0);
    stim_row_t row;
    row.stim.func         = op;
    row.stim.entry_index  = idx_t'(idx);
    row.reps              = reps;
    row.known             = known;
    row.want.status       = st;
    row.want.entry_out    = 8'(eo);
    row.want.entry_valid  = ev;
    row.want.live_count   = 9'(cnt);
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Random traffic. Mostly well-formed: allocations, removals of live entries and
  // reads that walk the list (sometimes removing the entry under the walk first).
  // A few percent is noise with a random index, which also hits the head and
  // free entries; while draining, an occasional init is sent as well.
  // ---------------------------------------------------------------------------
  function automatic item_t pick_item();
    item_t       it;
    int unsigned roll;
    int unsigned probe;
    int unsigned i;
    idx_t        victim;
    bit          found;
    roll           = $urandom_range(99);
    it.func        = FUNC_READ;
    it.entry_index = idx_t'($urandom_range(255));

    if (climbing) begin
      // linger a little once full so the full response gets exercised
      if (live_entries == POOL_ENTRIES) begin
        full_hits++;
        if (full_hits > 6) climbing = 1'b0;
      end
    end else if (live_entries <= low_mark) begin
      climbing  = 1'b1;
      full_hits = 0;
      low_mark  = $urandom_range(1, 40);
    end

    if (roll < 6) begin
      it.func = func_e'($urandom_range(FUNC_ALLOC, FUNC_READ));
      return it;
    end
    if (!climbing && roll < 7) begin
      it.func = FUNC_INIT;
      return it;
    end

    if (climbing ? (roll < 82) : (roll >= 92)) begin
      it.func = FUNC_ALLOC;
    end else if (climbing ? (roll < 94) : (roll >= 70)) begin
      it.func        = FUNC_READ;
      it.entry_index = walk_pos;
      walk_pos = (pool_fwd[walk_pos] < LINK_NONE) ? pool_fwd[walk_pos][7:0] : '0;
    end else begin
      it.func = FUNC_REMOVE;
      if ($urandom_range(2) == 0 && walk_pos != '0 && pool_used[walk_pos]) begin
        victim = walk_pos;
      end else begin
        found = 1'b0;
        probe = $urandom_range(255);
        victim = idx_t'(probe);
        for (i = 0; i < POOL_ENTRIES && !found; i++) begin
          victim = idx_t'(probe + i);
          found  = pool_used[victim] && victim != '0;
        end
      end
      it.entry_index = victim;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the transaction until it is taken.
  // Starts on a rising edge (or at time zero), drives on falling edges, returns
  // on the rising edge of acceptance with valid still high.
  // ---------------------------------------------------------------------------
  task automatic offer(input item_t it, input bit known, input result_t want);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    // taken at this edge: the shadow pool moves on now
    want = known ? want : predict_result(it);
    if (known) void'(predict_result(it));
    pending_results.push_back(want);
    sent_count++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold when asked for one.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every transaction out is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %p", out_result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_result.status == STAT_FULL) full_seen++;
        if (out_result.status == STAT_HEAD || out_result.status == STAT_NOT_USED)
          rejected_seen++;
        if (out_result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_result.status);
          errors++;
        end
        if (out_result.entry_out !== want.entry_out) begin
          $error("entry_out: expected %0d, got %0d", want.entry_out, out_result.entry_out);
          errors++;
        end
        if (out_result.entry_valid !== want.entry_valid) begin
          $error("entry_valid: expected %0d, got %0d", want.entry_valid,
                 out_result.entry_valid);
          errors++;
        end
        if (out_result.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count,
                 out_result.live_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_send_pct  [4];
    int unsigned phase_stall_pct [4];
    item_t       init_item;
    int          r;
    int          p;
    phase_send_pct  = '{0, 78, 0, 20};
    phase_stall_pct = '{0, 0, 78, 20};
    errors = 0; sent_count = 0; checked_count = 0;
    full_seen = 0; rejected_seen = 0;
    send_idle_pct = 0; stall_pct = 0; hold_req = 1'b0;
    climbing = 1'b1; full_hits = 0; low_mark = 8; walk_pos = '0;

    // block comes out of reset in the state an init leaves behind
    init_item = '0;
    init_item.func = FUNC_INIT;
    void'(predict_result(init_item));

    // fresh pool: read head, allocate, read links, bad and good removes, reuse of a freed entry
    add_row(FUNC_READ,     0, 1, 1, STAT_OK,       0, 0, 1);
    add_row(FUNC_ALLOC,    0, 1, 1, STAT_OK,       1, 1, 2);
    add_row(FUNC_ALLOC,    0, 1, 1, STAT_OK,       2, 1, 3);
    add_row(FUNC_READ,     1, 1, 1, STAT_OK,       2, 1, 3);
    add_row(FUNC_READ,   255, 1, 1, STAT_OK,       0, 0, 3);   // free entry, no link
    add_row(FUNC_REMOVE,   0, 1, 1, STAT_HEAD,     0, 0, 3);
    add_row(FUNC_REMOVE, 255, 1, 1, STAT_NOT_USED, 0, 0, 3);
    add_row(FUNC_REMOVE,   1, 1, 1, STAT_OK,       0, 0, 2);
    add_row(FUNC_READ,     1, 1, 1, STAT_OK,       2, 1, 2);   // removed entry keeps its link
    add_row(FUNC_REMOVE,   1, 1, 1, STAT_NOT_USED, 0, 0, 2);
    add_row(FUNC_READ,     0, 1, 1, STAT_OK,       2, 1, 2);
    add_row(FUNC_ALLOC,    0, 1, 1, STAT_OK,       1, 1, 3);   // freed entry reused first
    add_row(FUNC_REMOVE,   2, 1);                              // middle of the list
    add_row(FUNC_REMOVE,   1, 1);                              // tail
    // fill the pool to the brim, then bounce off the full limit
    add_row(FUNC_ALLOC,    0, POOL_ENTRIES - 1);
    add_row(FUNC_ALLOC,    0, 1, 1, STAT_FULL,     0, 0, POOL_ENTRIES);
    add_row(FUNC_READ,   255, 1);
    add_row(FUNC_REMOVE, 128, 1);
    add_row(FUNC_ALLOC,    0, 1);
    add_row(FUNC_ALLOC,    0, 1, 1, STAT_FULL,     0, 0, POOL_ENTRIES);
    add_row(FUNC_REMOVE, 8'hAA, 1);
    add_row(FUNC_REMOVE, 8'h55, 1);
    // init from a busy pool
    add_row(FUNC_INIT,     0, 1, 1, STAT_OK,       0, 1, 1);
    add_row(FUNC_READ,     1, 1, 1, STAT_OK,       0, 0, 1);
    add_row(FUNC_ALLOC,    0, 1, 1, STAT_OK,       1, 1, 2);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, no idling on either side
    for (r = 0; r < directed_rows.size(); r++)
      repeat (directed_rows[r].reps)
        offer(directed_rows[r].stim, directed_rows[r].known, directed_rows[r].want);
    directed_count = sent_count;
    // sender pauses until the block has caught up
    idle_input();
    wait_drained();

    // random part, one idling pattern per phase
    for (p = 0; p < 4; p++) begin
      send_idle_pct = phase_send_pct[p];
      stall_pct     = phase_stall_pct[p];
      if (p == 0) begin
        // long receiver hold while transactions keep coming, so the input backs up
        @(posedge clk);
        hold_req = 1'b1;
      end
      repeat (RANDOM_PER_PHASE) offer(pick_item(), 1'b0, '0);
      idle_input();
      wait_drained();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions (%0d directed) over four idling patterns, %0d results",
             sent_count, directed_count, checked_count);
    $display("Pool-full answers: %0d, refused removes: %0d, mismatches: %0d",
             full_seen, rejected_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sla_pkg.sv
rtl/core/sla_ram.sv
rtl/core/sla_seq.sv
rtl/core/slot_list_allocator.sv
rtl/core/sla_checker.sv
tb/slot_list_allocator_test.sv
